@@ rtl/core/pcbs_pkg.sv @@
`default_nettype none
package pcbs_pkg;

    // Kinds of input transfer, carried in s_tuser.
    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_LOAD_POWER = 2'd1;
    localparam logic [1:0] ACT_LOAD_CLOCK = 2'd2;

    // Power/FPGA machine states.
    localparam logic [2:0] PWR_IDLE     = 3'd0;
    localparam logic [2:0] PWR_DELAY    = 3'd1;
    localparam logic [2:0] PWR_LDO_WAIT = 3'd2;
    localparam logic [2:0] PWR_CFG_WAIT = 3'd3;
    localparam logic [2:0] PWR_DONE_WAIT = 3'd4;
    localparam logic [2:0] PWR_SETTLE   = 3'd5;

    // Clock machine states.
    localparam logic [2:0] CLK_IDLE     = 3'd0;
    localparam logic [2:0] CLK_WAIT     = 3'd1;
    localparam logic [2:0] CLK_CONFIG   = 3'd2;
    localparam logic [2:0] CLK_RESTART  = 3'd3;
    localparam logic [2:0] CLK_SELECT   = 3'd4;
    localparam logic [2:0] CLK_RELEASE  = 3'd5;
    localparam logic [2:0] CLK_PLL      = 3'd6;

    // Clock-chip stream requests.
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_CONFIG  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_STREAM4 = 2'd3;

    localparam logic [3:0] PLL_LOCKED_MASK = 4'b1111;
    localparam logic [3:0] PLL_LOCKED      = 4'b0011;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_REPORT_DELAY = 3'd0;
    localparam logic [2:0] REG_LDO_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_CONFIG_WAIT  = 3'd2;
    localparam logic [2:0] REG_DONE_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_FPGA_SETTLE  = 3'd4;
    localparam logic [2:0] REG_CLOCK_SETTLE = 3'd5;

    localparam logic [15:0] RST_REPORT_DELAY = 16'd1000;
    localparam logic [15:0] RST_LDO_TIMEOUT  = 16'd1000;
    localparam logic [15:0] RST_CONFIG_WAIT  = 16'd1000;
    localparam logic [15:0] RST_DONE_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_FPGA_SETTLE  = 16'd2560;
    localparam logic [15:0] RST_CLOCK_SETTLE = 16'd75;

    typedef struct packed {
        logic        fpga_ready_pulse;
        logic        clock_ok_pulse;
        logic        clock_error;
        logic        fpga_reset_released;
        logic [1:0]  clock_request;
        logic        system_fail;
        logic        fpga_done_ok;
        logic        fpga_program_pulse;
        logic        system_init_pulse;
        logic        supply_on;
        logic        report_ready;
    } result_t;

    typedef struct packed {
        logic [3:0]  pll_status;
        logic [1:0]  clock_select_bits;
        logic        fpga_done;
        logic        config_pin;
        logic        ldo_good;
        logic [15:0] load_count;
        logic [2:0]  load_state;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/core/power_and_clock_bringup_sequencer.sv @@
`default_nettype none
// Board bring-up sequencer stepped by one-millisecond ticks.
// The input stream carries one transfer per tick or load: s_tuser selects the
// kind (tick, load of the power machine, load of the clock machine) and s_tdata
// carries the load values and the sampled pin levels. Every accepted input
// transfer produces exactly one result transfer on the m_ side, which holds the
// sticky levels (supply, fail, done, reset release, clock error, report ready)
// and the one-tick pulses and clock-stream request caused by that tick.
// A transfer accepted into the result register shows its result on m_tdata
// with m_tvalid from the next cycle. Throughput is one transfer per cycle while
// the receiver takes results; the whole step is a few 16-bit decrements and
// compares between the sequencer state registers and the result register.
// When the receiver stalls, the result register holds its transfer and
// s_tready drops only while that register is full and not being taken, so the
// input side is taken in the same cycle the waiting result leaves.
// Reset (aresetn low, synchronous) returns both machines to idle, clears all
// flags and counts, restores register defaults and reloads the report count.
// The APB port writes the six 16-bit timing registers at byte addresses 0..20;
// it should only be written while no transfer is in flight. pready is tied high.
module power_and_clock_bringup_sequencer (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Input stream.
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [2:0] load_state, [18:3] load_count, [19] ldo_good, [20] config_pin,
    // [21] fpga_done, [23:22] clock_select_bits, [27:24] pll_status, [31:28] zero
    input  wire  [31:0]                  s_tdata,
    // [1:0] action
    input  wire  [1:0]                   s_tuser,
    // Result stream.
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [0] report_ready, [1] supply_on, [2] system_init_pulse,
    // [3] fpga_program_pulse, [4] fpga_done_ok, [5] system_fail,
    // [7:6] clock_request, [8] fpga_reset_released, [9] clock_error,
    // [10] clock_ok_pulse, [11] fpga_ready_pulse, [15:12] zero
    output logic [15:0]                  m_tdata,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [4:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pcbs_pkg::*;

    // Timing registers.
    logic [15:0] report_delay_reg, ldo_timeout_reg, config_wait_reg;
    logic [15:0] done_timeout_reg, fpga_settle_reg, clock_settle_reg;

    // Sequencer state.
    logic [15:0] report_count_reg, report_count_next;
    logic        report_flag_reg, report_flag_next;
    logic [2:0]  power_state_reg, power_state_next;
    logic [15:0] power_count_reg, power_count_next;
    logic [2:0]  clock_state_reg, clock_state_next;
    logic [15:0] clock_count_reg, clock_count_next;
    logic        supply_level_reg, supply_level_next;
    logic        fail_flag_reg, fail_flag_next;
    logic        done_flag_reg, done_flag_next;
    logic        clock_err_flag_reg, clock_err_flag_next;
    logic        reset_line_reg, reset_line_next;

    // Result register.
    logic        m_tvalid_reg;
    result_t     result_reg, result_next;

    item_t       item;
    logic        s_accept;
    logic        cfg_write;
    logic [2:0]  reg_index;
    logic [15:0] power_dec, clock_dec;
    logic        init_p, prog_p, ok_p, ready_p;
    logic [1:0]  req;

    assign item      = item_t'(s_tdata[27:0]);
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'd0, result_reg};
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign power_dec = power_count_reg - 16'd1;
    assign clock_dec = clock_count_reg - 16'd1;

    // Register read-back.
    always_comb begin
        unique case (reg_index)
            REG_REPORT_DELAY: prdata = {16'd0, report_delay_reg};
            REG_LDO_TIMEOUT:  prdata = {16'd0, ldo_timeout_reg};
            REG_CONFIG_WAIT:  prdata = {16'd0, config_wait_reg};
            REG_DONE_TIMEOUT: prdata = {16'd0, done_timeout_reg};
            REG_FPGA_SETTLE:  prdata = {16'd0, fpga_settle_reg};
            REG_CLOCK_SETTLE: prdata = {16'd0, clock_settle_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // One sequencer step. The clock machine is evaluated first; the power
    // machine then sees the reset release that this same tick may have made.
    always_comb begin
        report_count_next   = report_count_reg;
        report_flag_next    = report_flag_reg;
        power_state_next    = power_state_reg;
        power_count_next    = power_count_reg;
        clock_state_next    = clock_state_reg;
        clock_count_next    = clock_count_reg;
        supply_level_next   = supply_level_reg;
        fail_flag_next      = fail_flag_reg;
        done_flag_next      = done_flag_reg;
        clock_err_flag_next = clock_err_flag_reg;
        reset_line_next     = reset_line_reg;
        init_p  = 1'b0;
        prog_p  = 1'b0;
        ok_p    = 1'b0;
        ready_p = 1'b0;
        req     = REQ_NONE;

        unique case (s_tuser)
            ACT_LOAD_POWER: begin
                power_state_next = item.load_state;
                power_count_next = item.load_count;
            end
            ACT_LOAD_CLOCK: begin
                clock_state_next = item.load_state;
                clock_count_next = item.load_count;
            end
            ACT_TICK: begin
                if (report_count_reg == 16'd0) begin
                    report_flag_next = 1'b1;
                end else begin
                    report_count_next = report_count_reg - 16'd1;
                end

                unique case (clock_state_reg)
                    CLK_WAIT: begin
                        clock_count_next = clock_dec;
                        if (clock_dec == 16'd1) begin
                            clock_state_next = CLK_CONFIG;
                        end
                    end
                    CLK_CONFIG: begin
                        clock_state_next = CLK_IDLE;
                        req = REQ_CONFIG;
                    end
                    CLK_RESTART: begin
                        clock_count_next = clock_dec;
                        if (clock_dec == 16'd1) begin
                            clock_state_next = CLK_IDLE;
                            req = REQ_RESTART;
                        end
                    end
                    CLK_SELECT: begin
                        if (item.clock_select_bits == 2'd0) begin
                            req = REQ_STREAM4;
                            clock_state_next = CLK_RELEASE;
                            clock_count_next = clock_settle_reg;
                        end else begin
                            clock_state_next = CLK_IDLE;
                        end
                    end
                    CLK_RELEASE: begin
                        // Holds at a count of one until the FPGA is ready.
                        if (clock_count_reg == 16'd1) begin
                            if (item.fpga_done && (power_state_reg == PWR_IDLE ||
                                (power_state_reg == PWR_SETTLE &&
                                 power_count_reg != 16'd0))) begin
                                reset_line_next  = 1'b1;
                                clock_state_next = CLK_PLL;
                            end
                        end else begin
                            clock_count_next = clock_dec;
                        end
                    end
                    CLK_PLL: begin
                        if ((item.pll_status & PLL_LOCKED_MASK) == PLL_LOCKED) begin
                            ok_p = 1'b1;
                        end else begin
                            clock_err_flag_next = 1'b1;
                        end
                        clock_state_next = CLK_IDLE;
                    end
                    default: begin
                    end
                endcase

                unique case (power_state_reg)
                    PWR_DELAY: begin
                        power_count_next = power_dec;
                        if (power_dec == 16'd0) begin
                            if (!fail_flag_reg) begin
                                supply_level_next = 1'b1;
                                power_state_next  = PWR_LDO_WAIT;
                                power_count_next  = ldo_timeout_reg;
                            end else begin
                                power_state_next = PWR_IDLE;
                            end
                        end
                    end
                    PWR_LDO_WAIT: begin
                        if (item.ldo_good) begin
                            if (item.config_pin) begin
                                init_p = 1'b1;
                                power_state_next = PWR_CFG_WAIT;
                                power_count_next = config_wait_reg;
                            end else begin
                                fail_flag_next   = 1'b1;
                                power_state_next = PWR_IDLE;
                            end
                        end else begin
                            power_count_next = power_dec;
                            if (power_dec == 16'd0) begin
                                supply_level_next = 1'b0;
                                fail_flag_next    = 1'b1;
                                power_state_next  = PWR_IDLE;
                            end
                        end
                    end
                    PWR_CFG_WAIT: begin
                        power_count_next = power_dec;
                        if (power_dec == 16'd0) begin
                            prog_p = 1'b1;
                            power_state_next = PWR_DONE_WAIT;
                            power_count_next = done_timeout_reg;
                        end
                    end
                    PWR_DONE_WAIT: begin
                        if (item.fpga_done) begin
                            done_flag_next   = 1'b1;
                            power_state_next = PWR_SETTLE;
                            power_count_next = fpga_settle_reg;
                        end else begin
                            power_count_next = power_dec;
                            if (power_dec == 16'd0) begin
                                fail_flag_next   = 1'b1;
                                power_state_next = PWR_IDLE;
                            end
                        end
                    end
                    PWR_SETTLE: begin
                        if (power_count_reg != 16'd0) begin
                            power_count_next = power_dec;
                        end else if (reset_line_next) begin
                            power_state_next = PWR_IDLE;
                            ready_p = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // Unused action code: behaves like a load that writes nothing.
            end
        endcase

        result_next.report_ready        = report_flag_next;
        result_next.supply_on           = supply_level_next;
        result_next.system_init_pulse   = init_p;
        result_next.fpga_program_pulse  = prog_p;
        result_next.fpga_done_ok        = done_flag_next;
        result_next.system_fail         = fail_flag_next;
        result_next.clock_request       = req;
        result_next.fpga_reset_released = reset_line_next;
        result_next.clock_error         = clock_err_flag_next;
        result_next.clock_ok_pulse      = ok_p;
        result_next.fpga_ready_pulse    = ready_p;
    end

    // Timing registers and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_delay_reg   <= RST_REPORT_DELAY;
            ldo_timeout_reg    <= RST_LDO_TIMEOUT;
            config_wait_reg    <= RST_CONFIG_WAIT;
            done_timeout_reg   <= RST_DONE_TIMEOUT;
            fpga_settle_reg    <= RST_FPGA_SETTLE;
            clock_settle_reg   <= RST_CLOCK_SETTLE;
            report_count_reg   <= RST_REPORT_DELAY;
            report_flag_reg    <= 1'b0;
            power_state_reg    <= PWR_IDLE;
            power_count_reg    <= 16'd0;
            clock_state_reg    <= CLK_IDLE;
            clock_count_reg    <= 16'd0;
            supply_level_reg   <= 1'b0;
            fail_flag_reg      <= 1'b0;
            done_flag_reg      <= 1'b0;
            clock_err_flag_reg <= 1'b0;
            reset_line_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                report_count_reg   <= report_count_next;
                report_flag_reg    <= report_flag_next;
                power_state_reg    <= power_state_next;
                power_count_reg    <= power_count_next;
                clock_state_reg    <= clock_state_next;
                clock_count_reg    <= clock_count_next;
                supply_level_reg   <= supply_level_next;
                fail_flag_reg      <= fail_flag_next;
                done_flag_reg      <= done_flag_next;
                clock_err_flag_reg <= clock_err_flag_next;
                reset_line_reg     <= reset_line_next;
            end
            if (cfg_write) begin
                unique case (reg_index)
                    REG_REPORT_DELAY: begin
                        // Rearms the one-shot report countdown.
                        report_delay_reg <= pwdata[15:0];
                        report_count_reg <= pwdata[15:0];
                        report_flag_reg  <= 1'b0;
                    end
                    REG_LDO_TIMEOUT:  ldo_timeout_reg  <= pwdata[15:0];
                    REG_CONFIG_WAIT:  config_wait_reg  <= pwdata[15:0];
                    REG_DONE_TIMEOUT: done_timeout_reg <= pwdata[15:0];
                    REG_FPGA_SETTLE:  fpga_settle_reg  <= pwdata[15:0];
                    REG_CLOCK_SETTLE: clock_settle_reg <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register: loaded on every accepted transfer, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // The fail, done, clock error and reset release flags never clear.
    a_flags_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (fail_flag_reg && done_flag_reg) |=> (fail_flag_reg && done_flag_reg))
        else $error("fail or done flag cleared");

    a_reset_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (reset_line_reg || clock_err_flag_reg) |=>
        (reset_line_reg || clock_err_flag_reg))
        else $error("reset release and clock error both cleared");

    // A tick in the PLL check always returns the clock machine to idle.
    a_pll_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == ACT_TICK && clock_state_reg == CLK_PLL) |=>
        (clock_state_reg == CLK_IDLE))
        else $error("clock machine left PLL check for a state other than idle");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule
`default_nettype wire
